>>> rtl/gcq_pkg.sv
// ----------------------------------------------------------------------------
// gcq_pkg: shared types, constants and codebook ROM
// Lloyd-Max Gaussian codebooks (positive halves, Q3.12), config and stage
// types, and the centroid and decision-boundary lookup functions.
// ----------------------------------------------------------------------------
package gcq_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int MAX_CODE_BITS_DEF = 5;

  localparam int CODE_W    = 5;
  localparam int CODE_W1   = CODE_W + 1;
  localparam int BITS_W    = 3;
  localparam int SCALE_W   = 16;
  localparam int CB_MAG_W  = 15;
  localparam int CENT_W    = CB_MAG_W + 1;
  localparam int CENT_W1   = CENT_W + 1;
  localparam int CB_ROWS   = 5;
  localparam int CB_COLS   = 16;
  localparam int COL_W     = $clog2(CB_COLS);
  localparam int ROW_W     = $clog2(CB_ROWS);
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int Q_RND  = 128;
  localparam int Q_SH   = 8;
  localparam int DQ_RND = 2048;
  localparam int DQ_SH  = 12;

  localparam logic [BITS_W-1:0]  CODE_BITS_RST     = 3'd4;
  localparam logic [SCALE_W-1:0] NORM_SCALE_RST    = 16'd256;
  localparam logic [SCALE_W-1:0] RESTORE_SCALE_RST = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_BITS     = 2'd0,
    REG_NORM_SCALE    = 2'd1,
    REG_RESTORE_SCALE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_QUANT   = 1'b0,
    ACT_DEQUANT = 1'b1
  } action_t;

  typedef struct packed {
    logic [BITS_W-1:0]  bits;
    logic [SCALE_W-1:0] norm;
    logic [SCALE_W-1:0] restore;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [CODE_W-1:0] code;
    logic              last;
  } stage_t;

  localparam logic [CB_MAG_W-1:0] CB_HALF [CB_ROWS][CB_COLS] = '{
    '{0: 15'd3268, default: 15'd0},
    '{0: 15'd1855, 1: 15'd6187, default: 15'd0},
    '{0: 15'd1004, 1: 15'd3097, 2: 15'd5505, 3: 15'd8815, default: 15'd0},
    '{0: 15'd526,  1: 15'd1590, 2: 15'd2690, 3: 15'd3860,
      4: 15'd5145, 5: 15'd6627, 6: 15'd8475, 7: 15'd11193, default: 15'd0},
    '{15'd207,  15'd623,  15'd1042, 15'd1465, 15'd1895, 15'd2333, 15'd2783, 15'd3247,
      15'd3729, 15'd4233, 15'd4764, 15'd5329, 15'd5936, 15'd6597, 15'd7332, 15'd8174}
  };

  function automatic int op_w(input int sw);
    return (sw > CENT_W) ? sw : CENT_W;
  endfunction

  function automatic int prod_w(input int sw);
    return op_w(sw) + SCALE_W + 1;
  endfunction

  // Codebooks are symmetric: the upper half of the indexes maps onto the
  // stored table, the lower half onto its negated mirror image.
  function automatic logic signed [CENT_W-1:0] centroid(input logic [BITS_W-1:0] bits,
                                                        input logic [CODE_W-1:0] idx);
    logic [CODE_W1-1:0]  half;
    logic [CODE_W1-1:0]  m;
    logic [COL_W-1:0]    k;
    logic [ROW_W-1:0]    row;
    logic [CB_MAG_W-1:0] mag;
    half = CODE_W1'(1) << (bits - BITS_W'(1));
    m    = CODE_W1'(idx) & ((half << 1) - CODE_W1'(1));
    if (m >= half) begin
      k = COL_W'(m - half);
    end else begin
      k = COL_W'(half - CODE_W1'(1) - m);
    end
    row = ROW_W'(bits - BITS_W'(1));
    mag = CB_HALF[row][k];
    if (m >= half) begin
      return signed'({1'b0, mag});
    end
    return -signed'({1'b0, mag});
  endfunction

  // Sum of two neighboring centroids; twice the sample beyond it selects
  // the upper neighbor.
  function automatic logic signed [CENT_W1-1:0] boundary(input logic [BITS_W-1:0] bits,
                                                         input logic [CODE_W-1:0] i);
    return CENT_W1'(centroid(bits, i)) + CENT_W1'(centroid(bits, i + CODE_W'(1)));
  endfunction

endpackage

>>> rtl/gcq_cfg.sv
// ----------------------------------------------------------------------------
// gcq_cfg: configuration registers
// Holds code width and both scale factors and clamps the code width to the
// supported range.
// ----------------------------------------------------------------------------
module gcq_cfg #(
  parameter int MAX_CODE_BITS = gcq_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gcq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcq_pkg::CFG_W-1:0]      cfg_data,
  output gcq_pkg::cfg_t                  cfg
);
  import gcq_pkg::*;

  logic [BITS_W-1:0]  code_bits_r, code_bits_nxt;
  logic [SCALE_W-1:0] norm_scale_r, norm_scale_nxt;
  logic [SCALE_W-1:0] restore_scale_r, restore_scale_nxt;

  always_comb begin
    code_bits_nxt     = code_bits_r;
    norm_scale_nxt    = norm_scale_r;
    restore_scale_nxt = restore_scale_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CODE_BITS:     code_bits_nxt     = cfg_data[BITS_W-1:0];
        REG_NORM_SCALE:    norm_scale_nxt    = cfg_data[SCALE_W-1:0];
        REG_RESTORE_SCALE: restore_scale_nxt = cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_bits_r     <= CODE_BITS_RST;
      norm_scale_r    <= NORM_SCALE_RST;
      restore_scale_r <= RESTORE_SCALE_RST;
    end else begin
      code_bits_r     <= code_bits_nxt;
      norm_scale_r    <= norm_scale_nxt;
      restore_scale_r <= restore_scale_nxt;
    end
  end

  always_comb begin
    if (code_bits_r == '0) begin
      cfg.bits = BITS_W'(1);
    end else if (code_bits_r > BITS_W'(MAX_CODE_BITS)) begin
      cfg.bits = BITS_W'(MAX_CODE_BITS);
    end else begin
      cfg.bits = code_bits_r;
    end
    cfg.norm    = norm_scale_r;
    cfg.restore = restore_scale_r;
  end

endmodule

>>> rtl/gcq_scale.sv
// ----------------------------------------------------------------------------
// gcq_scale: shared scaling multiplier stage
// Multiplies the sample by the normalizing scale, or the looked-up centroid
// by the restore scale, and registers the exact product.
// ----------------------------------------------------------------------------
module gcq_scale #(
  parameter int SAMPLE_WIDTH = gcq_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  gcq_pkg::cfg_t                                      cfg,
  input  logic                                               up_valid,
  output logic                                               up_ready,
  input  gcq_pkg::stage_t                                    up_ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]                     up_sample,
  output logic                                               dn_valid,
  input  logic                                               dn_ready,
  output gcq_pkg::stage_t                                    dn_ctl,
  output logic signed [gcq_pkg::prod_w(SAMPLE_WIDTH)-1:0]    dn_prod
);
  import gcq_pkg::*;

  localparam int AW = op_w(SAMPLE_WIDTH);
  localparam int PW = prod_w(SAMPLE_WIDTH);

  logic signed [AW-1:0]     opa;
  logic signed [SCALE_W:0]  opb;
  logic signed [PW-1:0]     prod;
  logic                     v_r, v_nxt;
  stage_t                   ctl_r;
  logic signed [PW-1:0]     prod_r;

  always_comb begin
    if (up_ctl.action == ACT_QUANT) begin
      opa = AW'(up_sample);
      opb = signed'({1'b0, cfg.norm});
    end else begin
      opa = AW'(centroid(cfg.bits, up_ctl.code));
      opb = signed'({1'b0, cfg.restore});
    end
    prod = opa * opb;
  end

  assign up_ready = !v_r || dn_ready;
  assign v_nxt    = up_ready ? up_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctl_r  <= up_ctl;
      prod_r <= prod;
    end
  end

  assign dn_valid = v_r;
  assign dn_ctl   = ctl_r;
  assign dn_prod  = prod_r;

endmodule

>>> rtl/gcq_search.sv
// ----------------------------------------------------------------------------
// gcq_search: rounding, saturation and nearest-centroid search
// Rounds and saturates the scaled product, counts the decision boundaries
// below the sample in parallel and registers the result item.
// ----------------------------------------------------------------------------
module gcq_search #(
  parameter int SAMPLE_WIDTH  = gcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_CODE_BITS = gcq_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  gcq_pkg::cfg_t                                   cfg,
  input  logic                                            up_valid,
  output logic                                            up_ready,
  input  gcq_pkg::stage_t                                 up_ctl,
  input  logic signed [gcq_pkg::prod_w(SAMPLE_WIDTH)-1:0] up_prod,
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output logic [MAX_CODE_BITS-1:0]                        out_code_out,
  output logic signed [SAMPLE_WIDTH-1:0]                  out_value,
  output logic                                            out_last_out
);
  import gcq_pkg::*;

  localparam int PW    = prod_w(SAMPLE_WIDTH);
  localparam int CMP_W = op_w(SAMPLE_WIDTH) + 2;
  localparam int NB    = (1 << MAX_CODE_BITS) - 1;
  localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  logic signed [PW-1:0]           rq, rd, rnd;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [CMP_W-1:0]        x2;
  logic [CODE_W-1:0]              nb;
  logic [NB-1:0]                  gt;
  logic [CODE_W-1:0]              cnt;
  logic [CODE_W-1:0]              code_nxt;
  logic signed [SAMPLE_WIDTH-1:0] value_nxt;
  logic                           v_r, v_nxt;
  logic [CODE_W-1:0]              code_r;
  logic signed [SAMPLE_WIDTH-1:0] value_r;
  logic                           last_r;

  always_comb begin
    rq  = (up_prod + PW'(Q_RND)) >>> Q_SH;
    rd  = (up_prod + PW'(DQ_RND)) >>> DQ_SH;
    rnd = (up_ctl.action == ACT_QUANT) ? rq : rd;
    if (rnd > SAT_HI) begin
      x = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd < SAT_LO) begin
      x = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      x = rnd[SAMPLE_WIDTH-1:0];
    end
  end

  // Centroids are sorted, so the nearest index equals the number of
  // midpoints strictly below the sample; a tie keeps the lower index.
  always_comb begin
    x2  = CMP_W'(x) <<< 1;
    nb  = CODE_W'((CODE_W1'(1) << cfg.bits) - CODE_W1'(1));
    for (int i = 0; i < NB; i++) begin
      gt[i] = (CODE_W'(i) < nb) && (x2 > CMP_W'(boundary(cfg.bits, CODE_W'(i))));
    end
    cnt = CODE_W'($countones(gt));
  end

  always_comb begin
    if (up_ctl.action == ACT_QUANT) begin
      code_nxt  = cnt;
      value_nxt = '0;
    end else begin
      code_nxt  = up_ctl.code;
      value_nxt = x;
    end
  end

  assign up_ready = !v_r || !out_stall;
  assign v_nxt    = up_ready ? up_valid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      code_r  <= code_nxt;
      value_r <= value_nxt;
      last_r  <= up_ctl.last;
    end
  end

  assign out_valid    = v_r;
  assign out_code_out = MAX_CODE_BITS'(code_r);
  assign out_value    = value_r;
  assign out_last_out = last_r;

endmodule

>>> rtl/gaussian_codebook_quantizer.sv
// ----------------------------------------------------------------------------
// gaussian_codebook_quantizer: Lloyd-Max Gaussian scalar codec
// Quantizes scaled samples to the nearest codebook index, or restores a
// code to its scaled centroid, with 1 to 5 bit codebooks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_stall    in_action, in_sample, in_code_in, in_last_in
//  out      source     out_valid/out_stall  out_code_out, out_value, out_last_out
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
//  One item per cycle while the pipeline is not stalled; each item passes through
//  the input register, the multiplier product register and the result register.
//  Reset is synchronous and empties all stages; no clearing pass is needed.
//  A stall on the result side stops the pipeline stage by stage, and
//  in_stall rises only when all three stages hold items.
// ----------------------------------------------------------------------------
module gaussian_codebook_quantizer #(
  parameter int SAMPLE_WIDTH  = gcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_CODE_BITS = gcq_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [MAX_CODE_BITS-1:0]      in_code_in,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [MAX_CODE_BITS-1:0]      out_code_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_value,
  output logic                          out_last_out
);
  import gcq_pkg::*;

  localparam int PW = prod_w(SAMPLE_WIDTH);

  cfg_t                           cfg;
  logic [CODE_W-1:0]              code_mask;
  stage_t                         in_ctl;
  logic                           s1_v_r, s1_v_nxt;
  stage_t                         s1_ctl_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                           s1_rdy;
  logic                           s2_rdy;
  logic                           s2_v;
  stage_t                         s2_ctl;
  logic signed [PW-1:0]           s2_prod;
  logic                           s3_rdy;

  gcq_cfg #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    code_mask     = CODE_W'((CODE_W1'(1) << cfg.bits) - CODE_W1'(1));
    in_ctl.action = action_t'(in_action);
    in_ctl.code   = CODE_W'(in_code_in) & code_mask;
    in_ctl.last   = in_last_in;
  end

  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign s1_v_nxt = s1_rdy ? in_valid : s1_v_r;
  assign in_stall = !s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_ctl_r    <= in_ctl;
      s1_sample_r <= in_sample;
    end
  end

  gcq_scale #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s1_v_r),
    .up_ready (s2_rdy),
    .up_ctl   (s1_ctl_r),
    .up_sample(s1_sample_r),
    .dn_valid (s2_v),
    .dn_ready (s3_rdy),
    .dn_ctl   (s2_ctl),
    .dn_prod  (s2_prod)
  );

  gcq_search #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_valid    (s2_v),
    .up_ready    (s3_rdy),
    .up_ctl      (s2_ctl),
    .up_prod     (s2_prod),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_code_out(out_code_out),
    .out_value   (out_value),
    .out_last_out(out_last_out)
  );

endmodule

>>> rtl/gcq_checker.sv
// ----------------------------------------------------------------------------
// gcq_checker: port-level checks for the quantizer
// Watches the handshakes and the pipeline timing seen at the top level.
// ----------------------------------------------------------------------------
module gcq_checker #(
  parameter int SAMPLE_WIDTH  = gcq_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_CODE_BITS = gcq_pkg::MAX_CODE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [MAX_CODE_BITS-1:0]       out_code_out,
  input logic signed [SAMPLE_WIDTH-1:0] out_value,
  input logic                           out_last_out
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_out) &&
    $stable(out_value) && $stable(out_last_out))
    else $error("result item changed while stalled");

  // The input side only backs up when the result side is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free room in the pipeline");

  // With the sink open, an accepted item reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

  // With nothing accepted and the sink open, the pipeline drains empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall) && !out_stall ##1
    !(in_valid && !in_stall) && !out_stall ##1
    !(in_valid && !in_stall) && !out_stall |=> !out_valid)
    else $error("result item appeared without an input item");

endmodule

bind gaussian_codebook_quantizer gcq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .MAX_CODE_BITS(MAX_CODE_BITS)
) u_gcq_checker (.*);
